/* rtl/dcf_pkg.sv */
// Shared types, constants and register codes for the DCF77 time-code decoder.
`timescale 1ns / 1ps
`default_nettype none

package dcf_pkg;

    // Timestamp width; differences between edge stamps wrap at this width.
    localparam int TS_BITS = 32;

    // Configuration port geometry.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP_MIN  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP_MAX  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_JITTER   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_LEN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ONE_LEN  = 3'd4;

    // Register values after reset.
    localparam logic [11:0] GAP_MIN_RESET  = 12'd1700;
    localparam logic [11:0] GAP_MAX_RESET  = 12'd1900;
    localparam logic [7:0]  JITTER_RESET   = 8'd50;
    localparam logic [9:0]  ZERO_LEN_RESET = 10'd100;
    localparam logic [9:0]  ONE_LEN_RESET  = 10'd200;

    // Number of telegram bits and the saturating second count.
    localparam int             TELEGRAM_BITS = 59;
    localparam logic [5:0]     LAST_SECOND   = 6'd59;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_PARITY     = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;

    // Summer-time codes.
    localparam logic [1:0] DST_STANDARD = 2'd0;
    localparam logic [1:0] DST_SUMMER   = 2'd1;
    localparam logic [1:0] DST_UNKNOWN  = 2'd2;

    // Classified edge handed from the front to the back.
    typedef struct packed {
        logic is_mark;   // minute mark, otherwise end of a second pulse
        logic zero_hit;  // pulse width inside the bit-zero window
        logic one_hit;   // pulse width inside the bit-one window
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/dcf_front.sv */
// Front end: configuration registers, edge stamps and width classification.
`timescale 1ns / 1ps
`default_nettype none

module dcf_front
    import dcf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     accept,
    input  wire logic                     pulse_start,
    input  wire logic [TS_BITS-1:0]       time_ms,
    output logic                          push,
    output cmd_t                          push_cmd
);

    logic [11:0]        gap_min_reg;
    logic [11:0]        gap_max_reg;
    logic [7:0]         jitter_reg;
    logic [9:0]         zero_len_reg;
    logic [9:0]         one_len_reg;
    logic [TS_BITS-1:0] rise_stamp_reg;
    logic [TS_BITS-1:0] fall_stamp_reg;

    logic [TS_BITS-1:0] pause;
    logic [TS_BITS-1:0] width;
    logic               gap_hit;

    // True when lo - jitter < w < hi + jitter; a negative lower bound admits all.
    function automatic logic in_window(
        input logic [TS_BITS-1:0] w,
        input logic [11:0]        lo_nom,
        input logic [11:0]        hi_nom,
        input logic [7:0]         jit
    );
        logic [12:0] lo;
        logic [12:0] hi;
        logic        above;
        logic        below;
        lo    = {1'b0, lo_nom} - {5'b0, jit};
        hi    = {1'b0, hi_nom} + {5'b0, jit};
        above = lo[12] || (w > {{(TS_BITS-12){1'b0}}, lo[11:0]});
        below = w < {{(TS_BITS-13){1'b0}}, hi};
        return above && below;
    endfunction

    // Interval since the opposite edge, modulo the timestamp width.
    assign pause = time_ms - fall_stamp_reg;
    assign width = time_ms - rise_stamp_reg;

    // Classify the accepted edge.
    always_comb
    begin
        gap_hit           = in_window(pause, gap_min_reg, gap_max_reg, jitter_reg);
        push_cmd.is_mark  = pulse_start;
        push_cmd.zero_hit = in_window(width, {2'b0, zero_len_reg},
                                      {2'b0, zero_len_reg}, jitter_reg);
        push_cmd.one_hit  = in_window(width, {2'b0, one_len_reg},
                                      {2'b0, one_len_reg}, jitter_reg);
        push              = accept && (!pulse_start || gap_hit);
    end

    // Configuration registers and edge stamps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_min_reg    <= GAP_MIN_RESET;
            gap_max_reg    <= GAP_MAX_RESET;
            jitter_reg     <= JITTER_RESET;
            zero_len_reg   <= ZERO_LEN_RESET;
            one_len_reg    <= ONE_LEN_RESET;
            rise_stamp_reg <= '0;
            fall_stamp_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_GAP_MIN:  gap_min_reg  <= cfg_data[11:0];
                    REG_GAP_MAX:  gap_max_reg  <= cfg_data[11:0];
                    REG_JITTER:   jitter_reg   <= cfg_data[7:0];
                    REG_ZERO_LEN: zero_len_reg <= cfg_data[9:0];
                    REG_ONE_LEN:  one_len_reg  <= cfg_data[9:0];
                    default:      ;
                endcase
            end
            if (accept)
            begin
                if (pulse_start)
                begin
                    rise_stamp_reg <= time_ms;
                end
                else
                begin
                    fall_stamp_reg <= time_ms;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/dcf_queue.sv */
// Two-entry queue of classified edges between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module dcf_queue
    import dcf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/dcf_back.sv */
// Back end: telegram bit store, second counter and minute decoding.
`timescale 1ns / 1ps
`default_nettype none

module dcf_back
    import dcf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  cmd_t            head_cmd,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      status,
    output logic [6:0]      minute,
    output logic [5:0]      hour,
    output logic [5:0]      day_of_month,
    output logic [2:0]      weekday,
    output logic [4:0]      month,
    output logic [7:0]      year,
    output logic [1:0]      summer_time
);

    logic [TELEGRAM_BITS-1:0] tel_reg;
    logic [TELEGRAM_BITS-1:0] tel_next;
    logic [5:0]               sec_reg;
    logic                     synced_reg;
    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [6:0]               minute_reg;
    logic [5:0]               hour_reg;
    logic [5:0]               day_reg;
    logic [2:0]               weekday_reg;
    logic [4:0]               month_reg;
    logic [7:0]               year_reg;
    logic [1:0]               dst_reg;

    logic                     store_bit;
    logic [1:0]               st;
    logic [7:0]               minute_bcd;
    logic [7:0]               hour_bcd;
    logic [7:0]               day_bcd;
    logic [7:0]               month_bcd;
    logic [7:0]               year_bcd;
    logic [1:0]               dst_code;

    // Two BCD digits to binary: units plus ten times tens.
    function automatic logic [7:0] bcd8(input logic [7:0] b);
        return {4'b0, b[3:0]} + {1'b0, b[7:4], 3'b0} + {3'b0, b[7:4], 1'b0};
    endfunction

    // A mark waits for the output register; a falling edge never does.
    assign pop       = head_valid && (!head_cmd.is_mark || !out_valid_reg || out_ready);
    assign store_bit = pop && !head_cmd.is_mark && synced_reg && (sec_reg < LAST_SECOND);

    // Telegram bit update; a width in both windows ends as a one.
    always_comb
    begin
        tel_next = tel_reg;
        if (store_bit)
        begin
            if (head_cmd.zero_hit)
            begin
                tel_next[sec_reg] = 1'b0;
            end
            if (head_cmd.one_hit)
            begin
                tel_next[sec_reg] = 1'b1;
            end
        end
    end

    // Minute decode with three even-parity groups.
    always_comb
    begin
        if (!synced_reg || (sec_reg < LAST_SECOND))
        begin
            st = ST_INCOMPLETE;
        end
        else if ((^tel_reg[28:21]) || (^tel_reg[35:29]) || (^tel_reg[58:36]))
        begin
            st = ST_PARITY;
        end
        else
        begin
            st = ST_OK;
        end
        minute_bcd = bcd8({1'b0, tel_reg[27:21]});
        hour_bcd   = bcd8({2'b0, tel_reg[34:29]});
        day_bcd    = bcd8({2'b0, tel_reg[41:36]});
        month_bcd  = bcd8({3'b0, tel_reg[49:45]});
        year_bcd   = bcd8(tel_reg[57:50]);
        case ({tel_reg[18], tel_reg[17]})
            2'b10:   dst_code = DST_STANDARD;
            2'b01:   dst_code = DST_SUMMER;
            default: dst_code = DST_UNKNOWN;
        endcase
    end

    // Telegram state and the result word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tel_reg       <= '0;
            sec_reg       <= 6'd0;
            synced_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tel_reg <= tel_next;
            if (store_bit)
            begin
                sec_reg <= sec_reg + 6'd1;
            end
            if (pop && head_cmd.is_mark)
            begin
                synced_reg    <= 1'b1;
                sec_reg       <= 6'd0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, cleared fields unless the telegram is good.
    always_ff @(posedge clk)
    begin
        if (pop && head_cmd.is_mark)
        begin
            status_reg <= st;
            if (st == ST_OK)
            begin
                minute_reg  <= minute_bcd[6:0];
                hour_reg    <= hour_bcd[5:0];
                day_reg     <= day_bcd[5:0];
                weekday_reg <= tel_reg[44:42];
                month_reg   <= month_bcd[4:0];
                year_reg    <= year_bcd;
                dst_reg     <= dst_code;
            end
            else
            begin
                minute_reg  <= '0;
                hour_reg    <= '0;
                day_reg     <= '0;
                weekday_reg <= '0;
                month_reg   <= '0;
                year_reg    <= '0;
                dst_reg     <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign minute       = minute_reg;
    assign hour         = hour_reg;
    assign day_of_month = day_reg;
    assign weekday      = weekday_reg;
    assign month        = month_reg;
    assign year         = year_reg;
    assign summer_time  = dst_reg;

endmodule

`default_nettype wire

/* rtl/dcf77_time_decoder.sv */
// A minute-mark edge is written into the queue, then popped into the result word register
// once that register is free or being taken, so its result word shows after both.
// Throughput: one edge word per cycle while the queue has room; a two-entry queue parts
// the front from the back, and only a minute mark waits on the output register.
// Reset: asynchronous, active low; configuration returns to its defaults, stamps,
// telegram bits and second count clear, and the decoder starts unsynchronized.
`timescale 1ns / 1ps
`default_nettype none

module dcf77_time_decoder
    import dcf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     pulse_start,
    input  wire logic [TS_BITS-1:0]       time_ms,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [1:0]                    status,
    output logic [6:0]                    minute,
    output logic [5:0]                    hour,
    output logic [5:0]                    day_of_month,
    output logic [2:0]                    weekday,
    output logic [4:0]                    month,
    output logic [7:0]                    year,
    output logic [1:0]                    summer_time
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Input words are taken whenever the queue has room.
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // Front end classifies each edge.
    dcf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .pulse_start (pulse_start),
        .time_ms     (time_ms),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Queue between the two halves.
    dcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back end keeps the telegram and decodes minute marks.
    dcf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .minute       (minute),
        .hour         (hour),
        .day_of_month (day_of_month),
        .weekday      (weekday),
        .month        (month),
        .year         (year),
        .summer_time  (summer_time)
    );

endmodule

`default_nettype wire
